// File: src/fhrfs_pkg.sv
`default_nettype none
package fhrfs_pkg;

  localparam int unsigned KEY_W = 64;
  localparam int unsigned DROP_W = 32;

  typedef enum logic [2:0] {
    OP_PUSH       = 3'd0,
    OP_DROP_OLDER = 3'd1,
    OP_FIND_FRAME = 3'd2,
    OP_FIND_CYCLE = 3'd3,
    OP_CLEAR      = 3'd4
  } op_e;

  typedef struct packed {
    logic [KEY_W-1:0] frame;
    logic [KEY_W-1:0] cycle;
    logic [KEY_W-1:0] payload;
  } rec_t;

endpackage
`default_nettype wire

// File: src/fhrfs_in_if.sv
`default_nettype none
interface fhrfs_in_if;
  import fhrfs_pkg::*;

  logic             valid;
  logic             ready;
  logic [2:0]       operation;
  logic [KEY_W-1:0] rec_frame;
  logic [KEY_W-1:0] rec_cycle;
  logic [KEY_W-1:0] frame_payload;
  logic [KEY_W-1:0] target_key;

  modport source (
    output valid, operation, rec_frame, rec_cycle, frame_payload, target_key,
    input  ready
  );
  modport sink (
    input  valid, operation, rec_frame, rec_cycle, frame_payload, target_key,
    output ready
  );
endinterface
`default_nettype wire

// File: src/fhrfs_out_if.sv
`default_nettype none
interface fhrfs_out_if #(
  parameter int unsigned CNT_W = 11
);
  import fhrfs_pkg::*;

  logic              valid;
  logic              ready;
  logic              ok;
  logic [KEY_W-1:0]  found_frame;
  logic [KEY_W-1:0]  found_cycle;
  logic [KEY_W-1:0]  found_payload;
  logic [CNT_W-1:0]  live_count;
  logic [DROP_W-1:0] dropped_count;
  logic [KEY_W-1:0]  first_frame;
  logic [KEY_W-1:0]  last_frame;
  logic [KEY_W-1:0]  first_cycle;
  logic [KEY_W-1:0]  last_cycle;

  modport source (
    output valid, ok, found_frame, found_cycle, found_payload, live_count,
           dropped_count, first_frame, last_frame, first_cycle, last_cycle,
    input  ready
  );
  modport sink (
    input  valid, ok, found_frame, found_cycle, found_payload, live_count,
           dropped_count, first_frame, last_frame, first_cycle, last_cycle,
    output ready
  );
endinterface
`default_nettype wire

// File: src/fhrfs_ram.sv
`default_nettype none
module fhrfs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: src/frame_history_ring_floor_search_unit.sv
// Steps: a push, clear or unused code runs S_EXEC, then reads the oldest and newest records,
// or skips those end reads when the ring is empty afterward.
// A find makes at most ceil(log2(live + 1)) probes before the end reads; a probe is one read.
// A drop reads and checks the oldest record until one is kept or the ring is empty.
// One item in work at a time; a new beat is taken the cycle after the result beat leaves.
// Reset empties the ring, clears the drop count and turns recording on.
`default_nettype none
module frame_history_ring_floor_search_unit #(
  parameter int unsigned RING_DEPTH = 1024
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   cfg_we_i,
  input  wire logic   cfg_wdata_i,
  fhrfs_in_if.sink    in_i,
  fhrfs_out_if.source out_o
);
  import fhrfs_pkg::*;

  localparam int unsigned IW = $clog2(RING_DEPTH);
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam int unsigned SW = IW + 2;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_EXEC     = 10'b0000000010,
    S_DROP_RD  = 10'b0000000100,
    S_DROP_CHK = 10'b0000001000,
    S_SRCH_RD  = 10'b0000010000,
    S_SRCH_CHK = 10'b0000100000,
    S_OLD_RD   = 10'b0001000000,
    S_OLD_CHK  = 10'b0010000000,
    S_NEW_CHK  = 10'b0100000000,
    S_OUT      = 10'b1000000000
  } state_e;

  state_e            state_q, state_d;
  logic              en_q, en_d;
  logic [IW-1:0]     wpos_q, wpos_d;
  logic [IW-1:0]     tail_q, tail_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [DROP_W-1:0] drops_q, drops_d;
  logic [IW-1:0]     lo_q, lo_d;
  logic [IW-1:0]     hi_q, hi_d;

  op_e               op_q, op_d;
  rec_t              item_q, item_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic              ok_q, ok_d;
  rec_t              found_q, found_d;
  logic [KEY_W-1:0]  old_frame_q, old_frame_d;
  logic [KEY_W-1:0]  old_cycle_q, old_cycle_d;
  logic [KEY_W-1:0]  new_frame_q, new_frame_d;
  logic [KEY_W-1:0]  new_cycle_q, new_cycle_d;

  logic              mem_we;
  logic [IW-1:0]     mem_raddr;
  rec_t              mem_rdata;
  logic [IW-1:0]     mid;
  logic [IW:0]       slot_sum;
  logic [IW-1:0]     mid_slot;
  logic [IW-1:0]     newest_slot;
  logic [CW-1:0]     cnt_m1;
  logic [KEY_W-1:0]  probe_key;
  logic [SW-1:0]     ring_sum;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] x);
    if (x == IW'(RING_DEPTH - 1)) begin
      return '0;
    end
    return x + IW'(1);
  endfunction

  assign mid         = lo_q + ((hi_q - lo_q) >> 1);
  assign slot_sum    = {1'b0, tail_q} + {1'b0, mid};
  assign mid_slot    = (slot_sum >= (IW + 1)'(RING_DEPTH)) ?
                       IW'(slot_sum - (IW + 1)'(RING_DEPTH)) : slot_sum[IW-1:0];
  assign newest_slot = (wpos_q == '0) ? IW'(RING_DEPTH - 1) : wpos_q - IW'(1);
  assign cnt_m1      = cnt_q - CW'(1);
  assign probe_key   = (op_q == OP_FIND_CYCLE) ? mem_rdata.cycle : mem_rdata.frame;
  assign ring_sum    = SW'(tail_q) + SW'(cnt_q);

  always_comb begin
    case (state_q)
      S_SRCH_RD: mem_raddr = mid_slot;
      S_OLD_CHK: mem_raddr = newest_slot;
      default:   mem_raddr = tail_q;
    endcase
  end

  assign mem_we = (state_q == S_EXEC) && (op_q == OP_PUSH) && en_q;

  fhrfs_ram #(
    .WIDTH ($bits(rec_t)),
    .DEPTH (RING_DEPTH)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wpos_q),
    .wdata_i (item_q),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d     = state_q;
    en_d        = en_q;
    wpos_d      = wpos_q;
    tail_d      = tail_q;
    cnt_d       = cnt_q;
    drops_d     = drops_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    op_d        = op_q;
    item_d      = item_q;
    key_d       = key_q;
    ok_d        = ok_q;
    found_d     = found_q;
    old_frame_d = old_frame_q;
    old_cycle_d = old_cycle_q;
    new_frame_d = new_frame_q;
    new_cycle_d = new_cycle_q;

    if (cfg_we_i) begin
      en_d = cfg_wdata_i;
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          op_d           = op_e'(in_i.operation);
          item_d.frame   = in_i.rec_frame;
          item_d.cycle   = in_i.rec_cycle;
          item_d.payload = in_i.frame_payload;
          key_d          = in_i.target_key;
          ok_d           = 1'b0;
          found_d        = '0;
          state_d        = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_OLD_RD;
        case (op_q)
          OP_PUSH: begin
            if (en_q) begin
              wpos_d = wrap_inc(wpos_q);
              ok_d   = 1'b1;
              if (cnt_q != CW'(RING_DEPTH)) begin
                cnt_d = cnt_q + CW'(1);
              end else begin
                // Full ring: the oldest record is overwritten.
                tail_d  = wrap_inc(tail_q);
                drops_d = drops_q + DROP_W'(1);
              end
            end
          end
          OP_DROP_OLDER: state_d = S_DROP_RD;
          OP_FIND_FRAME, OP_FIND_CYCLE: begin
            if (cnt_q != '0) begin
              lo_d    = '0;
              hi_d    = cnt_m1[IW-1:0];
              state_d = S_SRCH_RD;
            end
          end
          OP_CLEAR: begin
            wpos_d  = '0;
            tail_d  = '0;
            cnt_d   = '0;
            drops_d = '0;
          end
          default: ;
        endcase
      end
      S_DROP_RD: begin
        state_d = (cnt_q == '0) ? S_OLD_RD : S_DROP_CHK;
      end
      S_DROP_CHK: begin
        if (mem_rdata.cycle < key_q) begin
          tail_d  = wrap_inc(tail_q);
          cnt_d   = cnt_m1;
          state_d = S_DROP_RD;
        end else begin
          state_d = S_OLD_RD;
        end
      end
      S_SRCH_RD: state_d = S_SRCH_CHK;
      S_SRCH_CHK: begin
        // Floor search: a match moves right, a miss moves left.
        if (probe_key <= key_q) begin
          ok_d    = 1'b1;
          found_d = mem_rdata;
          if (mid == hi_q) begin
            state_d = S_OLD_RD;
          end else begin
            lo_d    = mid + IW'(1);
            state_d = S_SRCH_RD;
          end
        end else begin
          if (mid == lo_q) begin
            state_d = S_OLD_RD;
          end else begin
            hi_d    = mid - IW'(1);
            state_d = S_SRCH_RD;
          end
        end
      end
      S_OLD_RD: begin
        if (cnt_q == '0) begin
          old_frame_d = '0;
          old_cycle_d = '0;
          new_frame_d = '0;
          new_cycle_d = '0;
          state_d     = S_OUT;
        end else begin
          state_d = S_OLD_CHK;
        end
      end
      S_OLD_CHK: begin
        old_frame_d = mem_rdata.frame;
        old_cycle_d = mem_rdata.cycle;
        state_d     = S_NEW_CHK;
      end
      S_NEW_CHK: begin
        new_frame_d = mem_rdata.frame;
        new_cycle_d = mem_rdata.cycle;
        state_d     = S_OUT;
      end
      S_OUT: begin
        if (out_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      en_q    <= 1'b1;
      wpos_q  <= '0;
      tail_q  <= '0;
      cnt_q   <= '0;
      drops_q <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
    end else begin
      state_q <= state_d;
      en_q    <= en_d;
      wpos_q  <= wpos_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
      drops_q <= drops_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    item_q      <= item_d;
    key_q       <= key_d;
    ok_q        <= ok_d;
    found_q     <= found_d;
    old_frame_q <= old_frame_d;
    old_cycle_q <= old_cycle_d;
    new_frame_q <= new_frame_d;
    new_cycle_q <= new_cycle_d;
  end

  assign in_i.ready          = (state_q == S_IDLE);
  assign out_o.valid         = (state_q == S_OUT);
  assign out_o.ok            = ok_q;
  assign out_o.found_frame   = found_q.frame;
  assign out_o.found_cycle   = found_q.cycle;
  assign out_o.found_payload = found_q.payload;
  assign out_o.live_count    = cnt_q;
  assign out_o.dropped_count = drops_q;
  assign out_o.first_frame   = old_frame_q;
  assign out_o.last_frame    = new_frame_q;
  assign out_o.first_cycle   = old_cycle_q;
  assign out_o.last_cycle    = new_cycle_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(RING_DEPTH))
    else $error("live count above ring depth");

  a_ptr_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ring_sum == SW'(wpos_q)) || (ring_sum == SW'(wpos_q) + SW'(RING_DEPTH)))
    else $error("tail, count and write position disagree");

  a_search_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH_RD) |-> (lo_q <= hi_q) && (SW'(hi_q) < SW'(cnt_q)))
    else $error("search window outside live records");

  a_ok_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ok) |->
      (op_q == OP_PUSH) || (op_q == OP_FIND_FRAME) || (op_q == OP_FIND_CYCLE))
    else $error("ok raised by an operation that cannot succeed");

  a_drop_keeps_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DROP_CHK) |=> $stable(wpos_q))
    else $error("drop moved the write position");

endmodule
`default_nettype wire
